>>> hdl/greedy_box_overlap_suppression_defines.svh
// assertion macros used by the checker
`ifndef GREEDY_BOX_OVERLAP_SUPPRESSION_DEFINES_SVH
`define GREEDY_BOX_OVERLAP_SUPPRESSION_DEFINES_SVH

// same-cycle implication, off during reset
`define GBOS_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("gbos check failed");

// next-cycle implication, off during reset
`define GBOS_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("gbos check failed");

// next-cycle implication that also covers reset
`define GBOS_ASSERT_ALWAYS(label, ante, cons) \
  label: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error("gbos check failed");

`endif

>>> hdl/gbos_pkg.sv
package gbos_pkg;

  localparam int EXT_W   = 17;
  localparam int AREA_W  = 2 * EXT_W;
  localparam int UNI_W   = AREA_W + 1;
  localparam int THR_W   = 16;
  localparam int PADDR_W = 3;

  localparam logic [THR_W-1:0]   THR_RESET = 16'd32768;
  localparam logic [PADDR_W-1:0] ADDR_THR  = 3'd0;

  typedef struct packed {
    logic [15:0] y_max;
    logic [15:0] x_max;
    logic [15:0] y_min;
    logic [15:0] x_min;
  } box_t;

  typedef struct packed {
    logic [7:0]  label;
    logic [15:0] score;
    box_t        box;
  } entry_t;

endpackage

>>> hdl/gbos_store.sv
module gbos_store #(
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  gbos_pkg::entry_t         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output gbos_pkg::entry_t         rd_data
);

  gbos_pkg::entry_t mem [DEPTH];
  gbos_pkg::entry_t rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

>>> hdl/gbos_iou.sv
module gbos_iou #(
  parameter int COORD_FRAC_BITS = 4
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          go,
  input  gbos_pkg::box_t                box_a,
  input  gbos_pkg::box_t                box_b,
  input  logic [gbos_pkg::THR_W-1:0]    thr,
  output logic                          done,
  output logic                          hit
);

  localparam logic [gbos_pkg::EXT_W-1:0] ONE = gbos_pkg::EXT_W'(1 << COORD_FRAC_BITS);

  // inclusive extent, clamped at zero
  function automatic logic [gbos_pkg::EXT_W-1:0] extent(logic [15:0] lo, logic [15:0] hi);
    logic [gbos_pkg::EXT_W-1:0] top;
    top = {1'b0, hi} + ONE;
    return (top <= {1'b0, lo}) ? '0 : top - {1'b0, lo};
  endfunction

  logic [15:0] xx1, yy1, xx2, yy2;
  logic [gbos_pkg::EXT_W-1:0] ex_a_r, ey_a_r, ex_b_r, ey_b_r, ex_i_r, ey_i_r;
  logic [gbos_pkg::AREA_W-1:0] area_a_r, area_b_r, inter_r, inter3_r;
  logic [gbos_pkg::UNI_W-1:0] uni_r;
  logic [gbos_pkg::THR_W+gbos_pkg::UNI_W-1:0] prod_r;
  logic [gbos_pkg::AREA_W+15:0] lhs_r;
  logic nz_r, hit_r;
  logic v1_r, v2_r, v3_r, v4_r, v5_r;

  assign xx1 = (box_a.x_min > box_b.x_min) ? box_a.x_min : box_b.x_min;
  assign yy1 = (box_a.y_min > box_b.y_min) ? box_a.y_min : box_b.y_min;
  assign xx2 = (box_a.x_max < box_b.x_max) ? box_a.x_max : box_b.x_max;
  assign yy2 = (box_a.y_max < box_b.y_max) ? box_a.y_max : box_b.y_max;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
      v5_r <= 1'b0;
    end else begin
      v1_r <= go;
      v2_r <= v1_r;
      v3_r <= v2_r;
      v4_r <= v3_r;
      v5_r <= v4_r;
    end
    ex_a_r   <= extent(box_a.x_min, box_a.x_max);
    ey_a_r   <= extent(box_a.y_min, box_a.y_max);
    ex_b_r   <= extent(box_b.x_min, box_b.x_max);
    ey_b_r   <= extent(box_b.y_min, box_b.y_max);
    ex_i_r   <= extent(xx1, xx2);
    ey_i_r   <= extent(yy1, yy2);
    area_a_r <= ex_a_r * ey_a_r;
    area_b_r <= ex_b_r * ey_b_r;
    inter_r  <= ex_i_r * ey_i_r;
    uni_r    <= {1'b0, area_a_r} + {1'b0, area_b_r} - {1'b0, inter_r};
    inter3_r <= inter_r;
    prod_r   <= thr * uni_r;
    lhs_r    <= {inter3_r, 16'h0000};
    nz_r     <= (uni_r != '0);
    hit_r    <= nz_r && ({2'b00, lhs_r} >= prod_r);
  end

  assign done = v5_r;
  assign hit  = hit_r;

endmodule

>>> hdl/greedy_box_overlap_suppression.sv
// insert: each stored entry with a lower score is read and moves down one place, then
//   the new item is written where it lands; a box that finds the store full is dropped
// suppression: each pair checked takes a memory read plus the 5-stage iou pipe, and
//   removed boxes are skipped; every kept row first reads its own box
// emission: surviving boxes are read out, removed ones skipped; results cannot be stalled
// reset clears control state, box count, overflow flag, alive marks, threshold to half
module greedy_box_overlap_suppression #(
  parameter int MAX_BOXES       = 64,
  parameter int COORD_FRAC_BITS = 4
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           start,
  output logic                           busy,
  input  logic [15:0]                    in_box_x_min,
  input  logic [15:0]                    in_box_y_min,
  input  logic [15:0]                    in_box_x_max,
  input  logic [15:0]                    in_box_y_max,
  input  logic [15:0]                    in_box_score,
  input  logic [7:0]                     in_class_label,
  input  logic                           in_set_last,
  output logic                           out_strobe,
  output logic [15:0]                    out_kept_x_min,
  output logic [15:0]                    out_kept_y_min,
  output logic [15:0]                    out_kept_x_max,
  output logic [15:0]                    out_kept_y_max,
  output logic [15:0]                    out_kept_score,
  output logic [7:0]                     out_kept_label,
  output logic                           out_run_last,
  output logic                           out_overflowed,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [gbos_pkg::PADDR_W-1:0]   paddr,
  input  logic [31:0]                    pwdata,
  output logic [31:0]                    prdata,
  output logic                           pready
);

  localparam int IW = $clog2(MAX_BOXES);
  localparam int CW = $clog2(MAX_BOXES + 1);

  typedef enum logic [3:0] {
    S_IDLE, S_INS_RD, S_INS_CMP, S_SUP_INIT, S_SUP_I, S_SUP_A,
    S_SUP_J, S_SUP_B, S_SUP_W, S_EM_I, S_EM_O
  } state_t;

  state_t state_r;
  logic [gbos_pkg::THR_W-1:0] thr_r;
  logic [CW-1:0] count_r, pi_r, pj_r;
  logic [MAX_BOXES-1:0] alive_r, alive_init;
  logic ovf_r, last_r;
  gbos_pkg::entry_t new_r, rd_data, wr_data;
  gbos_pkg::box_t a_r;
  logic wr_en, rd_en;
  logic [IW-1:0] wr_addr, rd_addr;
  logic iou_go, iou_done, iou_hit, later_alive;
  logic out_strobe_r, out_run_last_r, out_ovf_r;
  gbos_pkg::entry_t out_r;

  gbos_store #(.DEPTH(MAX_BOXES)) u_store (
    .clk(clk), .wr_en(wr_en), .wr_addr(wr_addr), .wr_data(wr_data),
    .rd_en(rd_en), .rd_addr(rd_addr), .rd_data(rd_data)
  );

  gbos_iou #(.COORD_FRAC_BITS(COORD_FRAC_BITS)) u_iou (
    .clk(clk), .rst_n(rst_n), .go(iou_go), .box_a(a_r), .box_b(rd_data.box),
    .thr(thr_r), .done(iou_done), .hit(iou_hit)
  );

  always_comb begin
    alive_init  = '0;
    later_alive = 1'b0;
    for (int k = 0; k < MAX_BOXES; k++) begin
      alive_init[k] = (CW'(k) < count_r);
      later_alive   = later_alive | (alive_r[k] & (CW'(k) > pi_r));
    end
  end

  // memory port control and iou start
  always_comb begin
    wr_en   = 1'b0;
    wr_addr = pi_r[IW-1:0];
    wr_data = new_r;
    rd_en   = 1'b0;
    rd_addr = pi_r[IW-1:0];
    iou_go  = (state_r == S_SUP_B);
    unique case (state_r)
      S_INS_RD: begin
        if (pi_r == '0) begin
          wr_en = 1'b1;
        end else begin
          rd_en   = 1'b1;
          rd_addr = IW'(pi_r - CW'(1));
        end
      end
      S_INS_CMP: begin
        wr_en = 1'b1;
        // lower score moves down one place
        if (rd_data.score < new_r.score) wr_data = rd_data;
      end
      S_SUP_I: rd_en = (pi_r != count_r) && alive_r[pi_r[IW-1:0]];
      S_SUP_J: begin
        rd_addr = pj_r[IW-1:0];
        rd_en   = (pj_r != count_r) && alive_r[pj_r[IW-1:0]];
      end
      S_EM_I: rd_en = (pi_r != count_r) && alive_r[pi_r[IW-1:0]];
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      thr_r        <= gbos_pkg::THR_RESET;
      count_r      <= '0;
      ovf_r        <= 1'b0;
      alive_r      <= '0;
      out_strobe_r <= 1'b0;
      pi_r         <= '0;
      pj_r         <= '0;
    end else begin
      out_strobe_r <= (state_r == S_EM_O);
      if (psel && penable && pwrite && paddr == gbos_pkg::ADDR_THR) begin
        thr_r <= pwdata[gbos_pkg::THR_W-1:0];
      end
      unique case (state_r)
        S_IDLE: begin
          if (start) begin
            new_r  <= '{label: in_class_label, score: in_box_score,
                        box: '{y_max: in_box_y_max, x_max: in_box_x_max,
                               y_min: in_box_y_min, x_min: in_box_x_min}};
            last_r <= in_set_last;
            if (count_r == CW'(MAX_BOXES)) begin
              ovf_r   <= 1'b1;
              state_r <= in_set_last ? S_SUP_INIT : S_IDLE;
            end else begin
              pi_r    <= count_r;
              state_r <= S_INS_RD;
            end
          end
        end
        S_INS_RD: begin
          if (pi_r == '0) begin
            count_r <= count_r + CW'(1);
            state_r <= last_r ? S_SUP_INIT : S_IDLE;
          end else begin
            state_r <= S_INS_CMP;
          end
        end
        S_INS_CMP: begin
          if (rd_data.score < new_r.score) begin
            pi_r    <= pi_r - CW'(1);
            state_r <= S_INS_RD;
          end else begin
            count_r <= count_r + CW'(1);
            state_r <= last_r ? S_SUP_INIT : S_IDLE;
          end
        end
        S_SUP_INIT: begin
          alive_r <= alive_init;
          pi_r    <= '0;
          state_r <= S_SUP_I;
        end
        S_SUP_I: begin
          if (pi_r == count_r) begin
            pi_r    <= '0;
            state_r <= S_EM_I;
          end else if (alive_r[pi_r[IW-1:0]]) begin
            state_r <= S_SUP_A;
          end else begin
            pi_r <= pi_r + CW'(1);
          end
        end
        S_SUP_A: begin
          a_r     <= rd_data.box;
          pj_r    <= pi_r + CW'(1);
          state_r <= S_SUP_J;
        end
        S_SUP_J: begin
          if (pj_r == count_r) begin
            pi_r    <= pi_r + CW'(1);
            state_r <= S_SUP_I;
          end else if (alive_r[pj_r[IW-1:0]]) begin
            state_r <= S_SUP_B;
          end else begin
            pj_r <= pj_r + CW'(1);
          end
        end
        S_SUP_B: state_r <= S_SUP_W;
        S_SUP_W: begin
          if (iou_done) begin
            if (iou_hit) alive_r[pj_r[IW-1:0]] <= 1'b0;
            pj_r    <= pj_r + CW'(1);
            state_r <= S_SUP_J;
          end
        end
        S_EM_I: begin
          if (pi_r == count_r) begin
            count_r <= '0;
            ovf_r   <= 1'b0;
            alive_r <= '0;
            state_r <= S_IDLE;
          end else if (alive_r[pi_r[IW-1:0]]) begin
            state_r <= S_EM_O;
          end else begin
            pi_r <= pi_r + CW'(1);
          end
        end
        S_EM_O: begin
          out_r          <= rd_data;
          out_run_last_r <= !later_alive;
          out_ovf_r      <= ovf_r;
          pi_r           <= pi_r + CW'(1);
          state_r        <= S_EM_I;
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign busy           = (state_r != S_IDLE);
  assign out_strobe     = out_strobe_r;
  assign out_kept_x_min = out_r.box.x_min;
  assign out_kept_y_min = out_r.box.y_min;
  assign out_kept_x_max = out_r.box.x_max;
  assign out_kept_y_max = out_r.box.y_max;
  assign out_kept_score = out_r.score;
  assign out_kept_label = out_r.label;
  assign out_run_last   = out_run_last_r;
  assign out_overflowed = out_ovf_r;
  assign prdata         = (paddr == gbos_pkg::ADDR_THR) ? {16'h0000, thr_r} : 32'h0;
  assign pready         = 1'b1;

endmodule

>>> hdl/gbos_checker.sv
`include "greedy_box_overlap_suppression_defines.svh"

module gbos_checker (
  input logic clk,
  input logic rst_n,
  input logic start,
  input logic busy,
  input logic out_strobe,
  input logic out_run_last
);

  `GBOS_ASSERT_ALWAYS(a_reset_idle, !rst_n, !busy && !out_strobe)
  `GBOS_ASSERT_NOW(a_strobe_busy, out_strobe, busy)
  `GBOS_ASSERT_NEXT(a_strobe_gap, out_strobe, !out_strobe)
  `GBOS_ASSERT_NEXT(a_last_ends_set, out_strobe && out_run_last, !out_strobe)
  `GBOS_ASSERT_NEXT(a_busy_needs_start, !busy && !start, !busy)

endmodule

bind greedy_box_overlap_suppression gbos_checker u_gbos_checker (
  .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
  .out_strobe(out_strobe), .out_run_last(out_run_last)
);

>>> bench/greedy_box_overlap_suppression_test.sv
`timescale 1ns / 100ps

module greedy_box_overlap_suppression_test;

  localparam int CAP = 64;
  localparam int ONE_PX = 16;
  localparam int STALL_LIMIT = 200000;

  typedef struct packed {
    logic [15:0] x_min;
    logic [15:0] y_min;
    logic [15:0] x_max;
    logic [15:0] y_max;
    logic [15:0] score;
    logic [7:0]  label;
    logic        last;
  } det_t;

  typedef struct packed {
    logic [15:0] x_min;
    logic [15:0] y_min;
    logic [15:0] x_max;
    logic [15:0] y_max;
    logic [15:0] score;
    logic [7:0]  label;
    logic        run_last;
    logic        overflowed;
  } kept_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic start = 1'b0;
  logic busy;
  logic [15:0] in_box_x_min = '0, in_box_y_min = '0, in_box_x_max = '0, in_box_y_max = '0;
  logic [15:0] in_box_score = '0;
  logic [7:0] in_class_label = '0;
  logic in_set_last = 1'b0;
  logic out_strobe;
  logic [15:0] out_kept_x_min, out_kept_y_min, out_kept_x_max, out_kept_y_max;
  logic [15:0] out_kept_score;
  logic [7:0] out_kept_label;
  logic out_run_last, out_overflowed;
  logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [gbos_pkg::PADDR_W-1:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;

  greedy_box_overlap_suppression dut (.*);

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  det_t pending_boxes[$];
  kept_t expected_kept[$];
  int errors = 0;
  int idle_pct = 0;
  int accepted = 0;
  int kept_seen = 0;
  int sets_done = 0;
  int stall_cycles = 0;

  // predictor state
  det_t sorted_boxes[CAP];
  int stored_count = 0;
  bit dropped = 1'b0;
  logic [15:0] iou_threshold = gbos_pkg::THR_RESET;

  task automatic add_box(det_t d);
    pending_boxes.insert(pending_boxes.size(), d);
  endtask

  function automatic longint unsigned span(longint unsigned lo, longint unsigned hi);
    if (hi + ONE_PX <= lo) return 0;
    return hi + ONE_PX - lo;
  endfunction

  function automatic bit too_close(det_t a, det_t b);
    longint unsigned inter, uni, area_a, area_b;
    inter = span(a.x_min > b.x_min ? a.x_min : b.x_min, a.x_max < b.x_max ? a.x_max : b.x_max)
          * span(a.y_min > b.y_min ? a.y_min : b.y_min, a.y_max < b.y_max ? a.y_max : b.y_max);
    area_a = span(a.x_min, a.x_max) * span(a.y_min, a.y_max);
    area_b = span(b.x_min, b.x_max) * span(b.y_min, b.y_max);
    uni = area_a + area_b - inter;
    if (uni == 0) return 1'b0;
    return inter * 65536 >= longint'(iou_threshold) * uni;
  endfunction

  task automatic predict_survivors(det_t d);
    int pos;
    bit alive[CAP];
    kept_t k;
    int last_idx;
    if (stored_count < CAP) begin
      pos = 0;
      while (pos < stored_count && sorted_boxes[pos].score >= d.score) pos++;
      for (int i = stored_count; i > pos; i--) sorted_boxes[i] = sorted_boxes[i-1];
      sorted_boxes[pos] = d;
      stored_count++;
    end else begin
      dropped = 1'b1;
    end
    if (!d.last) return;
    for (int i = 0; i < stored_count; i++) alive[i] = 1'b1;
    for (int i = 0; i < stored_count; i++)
      if (alive[i])
        for (int j = i + 1; j < stored_count; j++)
          if (alive[j] && too_close(sorted_boxes[i], sorted_boxes[j])) alive[j] = 1'b0;
    last_idx = -1;
    for (int i = 0; i < stored_count; i++)
      if (alive[i]) begin
        k = '{sorted_boxes[i].x_min, sorted_boxes[i].y_min, sorted_boxes[i].x_max,
              sorted_boxes[i].y_max, sorted_boxes[i].score, sorted_boxes[i].label,
              1'b0, dropped};
        expected_kept.insert(expected_kept.size(), k);
        last_idx = expected_kept.size() - 1;
      end
    if (last_idx >= 0) expected_kept[last_idx].run_last = 1'b1;
    stored_count = 0;
    dropped = 1'b0;
    sets_done++;
  endtask

  // driver
  always @(posedge clk) begin
    if (rst_n) begin
      if (start && !busy) begin
        predict_survivors({in_box_x_min, in_box_y_min, in_box_x_max, in_box_y_max,
                           in_box_score, in_class_label, in_set_last});
        accepted++;
      end
      if ((!start || !busy) && pending_boxes.size() > 0 &&
          $urandom_range(99) >= idle_pct) begin
        det_t d;
        d = pending_boxes.pop_front();
        start <= 1'b1;
        in_box_x_min <= d.x_min;
        in_box_y_min <= d.y_min;
        in_box_x_max <= d.x_max;
        in_box_y_max <= d.y_max;
        in_box_score <= d.score;
        in_class_label <= d.label;
        in_set_last <= d.last;
      end else if (!start || !busy) begin
        start <= 1'b0;
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    if (rst_n && out_strobe) begin
      kept_t got, want;
      got = '{out_kept_x_min, out_kept_y_min, out_kept_x_max, out_kept_y_max,
              out_kept_score, out_kept_label, out_run_last, out_overflowed};
      kept_seen++;
      if (expected_kept.size() == 0) begin
        $display("%0t: unexpected kept box %h", $time, got);
        errors++;
      end else begin
        want = expected_kept.pop_front();
        if (got !== want) begin
          $display("%0t: kept box mismatch expected %h actual %h", $time, want, got);
          errors++;
        end
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    if ((start && !busy) || out_strobe) stall_cycles <= 0;
    else stall_cycles <= stall_cycles + 1;
    if (stall_cycles > STALL_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  function automatic det_t random_box(bit last, bit cluster, logic [15:0] cx, logic [15:0] cy);
    det_t d;
    int w, h;
    if (cluster) begin
      w = $urandom_range(600, 40);
      h = $urandom_range(600, 40);
      d.x_min = 16'(cx + $urandom_range(120));
      d.y_min = 16'(cy + $urandom_range(120));
      d.x_max = 16'(d.x_min + w);
      d.y_max = 16'(d.y_min + h);
    end else begin
      d.x_min = 16'($urandom);
      d.y_min = 16'($urandom);
      d.x_max = 16'($urandom);
      d.y_max = 16'($urandom);
    end
    d.score = ($urandom_range(3) == 0) ? 16'($urandom_range(3) * 16384) : 16'($urandom);
    d.label = 8'($urandom);
    d.last = last;
    return d;
  endfunction

  task automatic write_threshold(logic [15:0] value);
    @(posedge clk);
    psel <= 1'b1; pwrite <= 1'b1; paddr <= gbos_pkg::ADDR_THR; pwdata <= {16'h0, value};
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    iou_threshold = value;
  endtask

  task automatic drain();
    while (pending_boxes.size() > 0 || start || expected_kept.size() > 0 || busy)
      @(posedge clk);
    repeat (50) @(posedge clk);
  endtask

  task automatic queue_set(int n);
    logic [15:0] cx, cy;
    cx = 16'($urandom_range(60000));
    cy = 16'($urandom_range(60000));
    for (int i = 0; i < n; i++)
      add_box(random_box(i == n - 1, $urandom_range(9) != 0, cx, cy));
  endtask

  initial begin
    det_t d;
    int sizes[4] = '{0, 80, 80, 32};
    logic [15:0] thr_list[4] = '{16'h0000, 16'hffff, 16'h4ccd, 16'h8000};
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    write_threshold(gbos_pkg::THR_RESET);

    // directed: extremes, identical boxes, inverted and zero-area boxes, ties
    add_box('{16'h0000, 16'h0000, 16'hffff, 16'hffff, 16'hffff, 8'hff, 1'b1});
    add_box('{16'h0100, 16'h0100, 16'h0300, 16'h0300, 16'h8000, 8'h01, 1'b0});
    add_box('{16'h0100, 16'h0100, 16'h0300, 16'h0300, 16'h8000, 8'h02, 1'b0});
    add_box('{16'h0500, 16'h0500, 16'h0100, 16'h0100, 16'h0000, 8'h03, 1'b0});
    add_box('{16'hffff, 16'hffff, 16'h0000, 16'h0000, 16'h0000, 8'h04, 1'b0});
    add_box('{16'h0110, 16'h0110, 16'h0310, 16'h0310, 16'hffff, 8'h05, 1'b1});
    drain();
    write_threshold(16'h0000);
    add_box('{16'h0000, 16'h0000, 16'h0010, 16'h0010, 16'h1000, 8'h06, 1'b0});
    add_box('{16'h0010, 16'h0010, 16'h0020, 16'h0020, 16'h1000, 8'h07, 1'b0});
    add_box('{16'h0030, 16'h0030, 16'h0000, 16'h0000, 16'h0800, 8'h08, 1'b0});
    add_box('{16'h4000, 16'h4000, 16'h4100, 16'h4100, 16'h0001, 8'h09, 1'b1});
    drain();
    // overflow: capacity plus three, last three dropped
    write_threshold(16'hffff);
    for (int i = 0; i < CAP + 3; i++) begin
      d = random_box(i == CAP + 2, 1'b0, 16'd0, 16'd0);
      add_box(d);
    end
    drain();

    for (int phase = 0; phase < 4; phase++) begin
      idle_pct = sizes[phase];
      write_threshold(thr_list[phase]);
      for (int s = 0; s < 10; s++) begin
        if ($urandom_range(7) == 0) begin
          for (int i = 0; i < 4; i++) add_box(random_box(1'b0, 1'b0, 16'd0, 16'd0));
        end
        queue_set($urandom_range(8, 1));
      end
      drain();
    end
    write_threshold(16'($urandom));
    queue_set(30);
    drain();

    $display("sent %0d boxes in %0d sets, checked %0d kept boxes", accepted, sets_done,
             kept_seen);
    $display("thresholds zero, full scale and mid, overflow and idle phases covered");
    if (errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end
endmodule
